FILE: rtl/core/bfl_pkg.sv
// Shared types, character codes and helper functions of the bracket format lexer.
`timescale 1ns / 1ps

package bfl_pkg;

    localparam int POS_BITS_DEF = 16;

    typedef enum logic [1:0] {
        M_OUTER,
        M_WORD,
        M_STRING,
        M_COMMENT
    } t_mode;

    typedef enum logic [2:0] {
        K_WORD   = 3'd0,
        K_STRING = 3'd1,
        K_SYMBOL = 3'd2,
        K_ERROR  = 3'd3,
        K_END    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE       = 3'd0,
        E_BAD_SCOPE  = 3'd1,
        E_BAD_WORD   = 3'd2,
        E_BAD_ESCAPE = 3'd3,
        E_BAD_STRING = 3'd4
    } t_err;

    typedef struct packed {
        t_kind       kind;
        t_err        code;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic [7:0]  bad;
        logic        last;
    } t_token;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_LBRACK     = 8'h5B;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_RBRACK     = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_TILDE      = 8'h7E;

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_LBRACE) ||
               (c == CH_RBRACE) || (c == CH_COMMA);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDERSCORE) ||
               (c == CH_DASH) || (c == CH_DOT);
    endfunction

    function automatic logic is_printable(input logic [7:0] c);
        return (c >= CH_SPACE) && (c <= CH_TILDE);
    endfunction

    function automatic logic [15:0] clamp16(input logic [31:0] w);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

FILE: rtl/core/bfl_in_if.sv
// Input byte channel of the bracket format lexer.
`timescale 1ns / 1ps

interface bfl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

FILE: rtl/core/bfl_out_if.sv
// Token result channel of the bracket format lexer.
`timescale 1ns / 1ps

interface bfl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [2:0]  error_code;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [7:0]  offending_byte;
    logic        last_of_run;

    modport source (output valid, output token_kind, output error_code, output start_offset,
                    output token_length, output line_number, output column_number,
                    output offending_byte, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input error_code, input start_offset,
                    input token_length, input line_number, input column_number,
                    input offending_byte, input last_of_run, output ready);
endinterface

FILE: rtl/core/bracket_format_lexer.sv
// Top level of the bracket format lexer: input register, lexer state and result buffer.
`timescale 1ns / 1ps

// Byte-serial lexer with one byte of lookahead. Each byte transaction is registered
// in the input register and lexed from there; while the result channel is ready,
// plain text streams at one byte per clock. A byte flagged end_of_text produces up
// to three tokens (the pending token, the token of the final byte and the end token);
// they leave the three-entry result buffer one per cycle while the result channel is ready.

module bracket_format_lexer import bfl_pkg::*; #(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfl_in_if.sink    i_in,
    bfl_out_if.source o_out
);

    localparam int PB = POSITION_BITS;

    logic                r_in_vld;
    logic [7:0]          r_in_byte;
    logic                r_in_eot;

    t_mode               r_mode;
    logic [7:0]          r_held;
    logic                r_held_vld;
    logic                r_skip;
    logic [PB-1:0]       r_off;
    logic [PB-1:0]       r_begin;
    logic [PB-1:0]       r_line;
    logic [PB-1:0]       r_col;
    logic                r_halt;

    t_token              r_ob [3];
    logic [1:0]          r_ob_cnt;
    logic [1:0]          r_ob_head;
    t_token              n_ob [3];
    logic [1:0]          n_ob_cnt;

    logic                buf_free;
    logic                proc;
    logic                out_fire;

    t_mode               a_mode;
    logic                a_skip;
    logic [PB-1:0]       a_off;
    logic [PB-1:0]       a_begin;
    logic [PB-1:0]       a_line;
    logic [PB-1:0]       a_col;
    logic                a_emit;
    logic                a_fail;
    t_token              a_tok;
    logic                en_a;

    t_mode               sa_mode;
    logic                sa_skip;
    logic [PB-1:0]       sa_off;
    logic [PB-1:0]       sa_begin;
    logic [PB-1:0]       sa_line;
    logic [PB-1:0]       sa_col;
    logic                sa_halt;

    t_mode               b_mode;
    logic                b_skip;
    logic [PB-1:0]       b_off;
    logic [PB-1:0]       b_begin;
    logic [PB-1:0]       b_line;
    logic [PB-1:0]       b_col;
    logic                b_emit;
    logic                b_fail;
    t_token              b_tok;
    logic                en_b;

    logic [PB-1:0]       sb_off;
    logic [PB-1:0]       sb_line;
    logic [PB-1:0]       sb_col;
    t_token              end_tok;
    t_token              cur;

    assign out_fire    = o_out.valid && o_out.ready;
    assign buf_free    = (r_ob_cnt == 2'd0) || ((r_ob_cnt == 2'd1) && o_out.ready);
    assign proc        = r_in_vld && buf_free;
    assign i_in.ready  = !r_in_vld || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_eot  <= i_in.end_of_text;
        end
    end

    bfl_lex_step #(.PB(PB)) u_step_held (
        .i_mode  (r_mode),
        .i_skip  (r_skip),
        .i_off   (r_off),
        .i_begin (r_begin),
        .i_line  (r_line),
        .i_col   (r_col),
        .i_c     (r_held),
        .i_n     (r_in_byte),
        .i_last  (1'b0),
        .o_mode  (a_mode),
        .o_skip  (a_skip),
        .o_off   (a_off),
        .o_begin (a_begin),
        .o_line  (a_line),
        .o_col   (a_col),
        .o_emit  (a_emit),
        .o_fail  (a_fail),
        .o_tok   (a_tok)
    );

    assign en_a     = !r_halt && r_held_vld;
    assign sa_mode  = en_a ? a_mode  : r_mode;
    assign sa_skip  = en_a ? a_skip  : r_skip;
    assign sa_off   = en_a ? a_off   : r_off;
    assign sa_begin = en_a ? a_begin : r_begin;
    assign sa_line  = en_a ? a_line  : r_line;
    assign sa_col   = en_a ? a_col   : r_col;
    assign sa_halt  = r_halt || (en_a && a_fail);

    bfl_lex_step #(.PB(PB)) u_step_last (
        .i_mode  (sa_mode),
        .i_skip  (sa_skip),
        .i_off   (sa_off),
        .i_begin (sa_begin),
        .i_line  (sa_line),
        .i_col   (sa_col),
        .i_c     (r_in_byte),
        .i_n     (CH_NUL),
        .i_last  (1'b1),
        .o_mode  (b_mode),
        .o_skip  (b_skip),
        .o_off   (b_off),
        .o_begin (b_begin),
        .o_line  (b_line),
        .o_col   (b_col),
        .o_emit  (b_emit),
        .o_fail  (b_fail),
        .o_tok   (b_tok)
    );

    assign en_b    = r_in_eot && !sa_halt;
    assign sb_off  = en_b ? b_off  : sa_off;
    assign sb_line = en_b ? b_line : sa_line;
    assign sb_col  = en_b ? b_col  : sa_col;

    always_comb begin
        end_tok       = '0;
        end_tok.kind  = K_END;
        end_tok.code  = E_NONE;
        end_tok.start = clamp16(32'(sb_off) & 32'h0000_FFFF);
        end_tok.len   = 16'd0;
        end_tok.line  = clamp16(32'(sb_line));
        end_tok.col   = clamp16(32'(sb_col));
        end_tok.bad   = CH_NUL;
        end_tok.last  = 1'b0;
    end

    always_comb begin
        n_ob[0]  = '0;
        n_ob[1]  = '0;
        n_ob[2]  = '0;
        n_ob_cnt = 2'd0;
        if (en_a && a_emit) begin
            n_ob[n_ob_cnt] = a_tok;
            n_ob_cnt       = n_ob_cnt + 2'd1;
        end
        if (en_b && b_emit) begin
            n_ob[n_ob_cnt] = b_tok;
            n_ob_cnt       = n_ob_cnt + 2'd1;
        end
        if (r_in_eot) begin
            n_ob[n_ob_cnt] = end_tok;
            n_ob_cnt       = n_ob_cnt + 2'd1;
        end
        if (n_ob_cnt != 2'd0) begin
            n_ob[n_ob_cnt - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_OUTER;
            r_held     <= 8'h00;
            r_held_vld <= 1'b0;
            r_skip     <= 1'b0;
            r_off      <= '0;
            r_begin    <= '0;
            r_line     <= PB'(1);
            r_col      <= PB'(1);
            r_halt     <= 1'b0;
        end else if (proc) begin
            if (r_in_eot) begin
                r_mode     <= M_OUTER;
                r_held     <= 8'h00;
                r_held_vld <= 1'b0;
                r_skip     <= 1'b0;
                r_off      <= '0;
                r_begin    <= '0;
                r_line     <= PB'(1);
                r_col      <= PB'(1);
                r_halt     <= 1'b0;
            end else begin
                r_mode     <= sa_mode;
                r_held     <= r_in_byte;
                r_held_vld <= 1'b1;
                r_skip     <= sa_skip;
                r_off      <= sa_off;
                r_begin    <= sa_begin;
                r_line     <= sa_line;
                r_col      <= sa_col;
                r_halt     <= sa_halt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt  <= 2'd0;
            r_ob_head <= 2'd0;
        end else if (proc) begin
            r_ob_cnt  <= n_ob_cnt;
            r_ob_head <= 2'd0;
        end else if (out_fire) begin
            r_ob_cnt  <= r_ob_cnt - 2'd1;
            r_ob_head <= (r_ob_head == 2'd2) ? 2'd0 : r_ob_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_ob[0] <= n_ob[0];
            r_ob[1] <= n_ob[1];
            r_ob[2] <= n_ob[2];
        end
    end

    assign cur = r_ob[r_ob_head];

    assign o_out.valid          = (r_ob_cnt != 2'd0);
    assign o_out.token_kind     = cur.kind;
    assign o_out.error_code     = cur.code;
    assign o_out.start_offset   = cur.start;
    assign o_out.token_length   = cur.len;
    assign o_out.line_number    = cur.line;
    assign o_out.column_number  = cur.col;
    assign o_out.offending_byte = cur.bad;
    assign o_out.last_of_run    = cur.last;

    logic unused_b;
    assign unused_b = ^{b_mode, b_skip, b_begin, b_fail};

endmodule

FILE: rtl/core/bfl_lex_step.sv
// Combinational lexing of one character with one character of lookahead.
`timescale 1ns / 1ps

module bfl_lex_step import bfl_pkg::*; #(
    parameter int PB = POS_BITS_DEF
) (
    input  t_mode         i_mode,
    input  logic          i_skip,
    input  logic [PB-1:0] i_off,
    input  logic [PB-1:0] i_begin,
    input  logic [PB-1:0] i_line,
    input  logic [PB-1:0] i_col,
    input  logic [7:0]    i_c,
    input  logic [7:0]    i_n,
    input  logic          i_last,
    output t_mode         o_mode,
    output logic          o_skip,
    output logic [PB-1:0] o_off,
    output logic [PB-1:0] o_begin,
    output logic [PB-1:0] o_line,
    output logic [PB-1:0] o_col,
    output logic          o_emit,
    output logic          o_fail,
    output t_token        o_tok
);

    localparam logic [PB-1:0] PMAX = '1;

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        return (v == PMAX) ? v : v + PB'(1);
    endfunction

    logic [PB-1:0] off1;
    logic [PB-1:0] line1;
    logic [PB-1:0] col1;
    logic [PB-1:0] col2;
    logic          word_end;
    logic          word_bad;
    logic          esc_bad;

    logic          emit_ok;
    logic          fail;
    t_kind         kind;
    t_err          code;
    logic [PB-1:0] start_pos;
    logic [PB-1:0] len;
    logic [PB-1:0] colv;
    logic [7:0]    bad;

    assign off1     = i_off + PB'(1);
    assign line1    = (i_c == CH_LF) ? sat_inc(i_line) : i_line;
    assign col1     = (i_c == CH_LF) ? PB'(1) : sat_inc(i_col);
    assign col2     = sat_inc(col1);
    assign word_end = i_last || is_white(i_n) || is_symbol(i_n);
    assign word_bad = !is_word(i_n);
    assign esc_bad  = i_last || !is_printable(i_n);

    always_comb begin
        o_mode  = i_mode;
        o_skip  = i_skip;
        o_off   = off1;
        o_begin = i_begin;
        o_line  = i_line;
        o_col   = i_col;
        if (i_skip) begin
            o_skip = 1'b0;
        end else begin
            o_line = line1;
            o_col  = col1;
            unique case (i_mode)
                M_OUTER: begin
                    if (i_c == CH_SLASH && i_n == CH_STAR) begin
                        o_mode = M_COMMENT;
                        o_skip = 1'b1;
                        o_col  = col2;
                    end else if (i_c == CH_DQUOTE) begin
                        o_begin = off1;
                        o_mode  = M_STRING;
                    end else if (is_symbol(i_c) || is_white(i_c)) begin
                        o_mode = M_OUTER;
                    end else if (is_word(i_c)) begin
                        o_begin = i_off;
                        if (!word_end) begin
                            o_mode = M_WORD;
                        end
                    end
                end
                M_WORD: begin
                    if (word_end) begin
                        o_mode = M_OUTER;
                    end
                end
                M_COMMENT: begin
                    if (i_c == CH_STAR && i_n == CH_SLASH) begin
                        o_mode = M_OUTER;
                        o_skip = 1'b1;
                        o_col  = col2;
                    end
                end
                M_STRING: begin
                    if (i_c == CH_BSLASH) begin
                        if (!esc_bad) begin
                            o_skip = 1'b1;
                            o_col  = col2;
                        end
                    end else if (i_c == CH_DQUOTE) begin
                        o_mode = M_OUTER;
                    end
                end
                default: o_mode = i_mode;
            endcase
        end
    end

    always_comb begin
        emit_ok   = 1'b0;
        fail      = 1'b0;
        kind      = K_WORD;
        code      = E_NONE;
        start_pos = i_off;
        len       = PB'(1);
        colv      = col1;
        bad       = CH_NUL;
        if (!i_skip) begin
            unique case (i_mode)
                M_OUTER: begin
                    if (i_c == CH_SLASH && i_n == CH_STAR) begin
                        emit_ok = 1'b0;
                    end else if (i_c == CH_DQUOTE) begin
                        emit_ok = 1'b0;
                    end else if (is_symbol(i_c)) begin
                        emit_ok = 1'b1;
                        kind    = K_SYMBOL;
                    end else if (is_white(i_c)) begin
                        emit_ok = 1'b0;
                    end else if (is_word(i_c)) begin
                        if (word_end) begin
                            emit_ok = 1'b1;
                        end else if (word_bad) begin
                            fail      = 1'b1;
                            code      = E_BAD_WORD;
                            start_pos = off1;
                            bad       = i_n;
                        end
                    end else begin
                        fail = 1'b1;
                        code = E_BAD_SCOPE;
                        bad  = i_c;
                    end
                end
                M_WORD: begin
                    if (word_end) begin
                        emit_ok   = 1'b1;
                        start_pos = i_begin;
                        len       = off1 - i_begin;
                    end else if (word_bad) begin
                        fail      = 1'b1;
                        code      = E_BAD_WORD;
                        start_pos = off1;
                        bad       = i_n;
                    end
                end
                M_COMMENT: emit_ok = 1'b0;
                M_STRING: begin
                    if (i_c == CH_BSLASH) begin
                        if (esc_bad) begin
                            fail      = 1'b1;
                            code      = E_BAD_ESCAPE;
                            start_pos = off1;
                            colv      = col2;
                            bad       = i_last ? CH_NUL : i_n;
                        end
                    end else if (i_c == CH_DQUOTE) begin
                        emit_ok   = 1'b1;
                        kind      = K_STRING;
                        start_pos = i_begin;
                        len       = i_off - i_begin;
                    end else if (i_c == CH_LF || i_c == CH_NUL) begin
                        fail = 1'b1;
                        code = E_BAD_STRING;
                        bad  = i_c;
                    end
                end
                default: emit_ok = 1'b0;
            endcase
        end
        if (fail) begin
            kind = K_ERROR;
        end
    end

    assign o_emit = emit_ok || fail;
    assign o_fail = fail;

    always_comb begin
        o_tok       = '0;
        o_tok.kind  = kind;
        o_tok.code  = code;
        o_tok.start = clamp16(32'(start_pos) & 32'h0000_FFFF);
        o_tok.len   = clamp16(32'(len) & 32'h0000_FFFF);
        o_tok.line  = clamp16(32'(line1));
        o_tok.col   = clamp16(32'(colv));
        o_tok.bad   = bad;
        o_tok.last  = 1'b0;
    end

endmodule

FILE: rtl/core/bfl_checker.sv
// Port-level checks of the bracket format lexer and their binding to the top level.
`timescale 1ns / 1ps

module bfl_checker import bfl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_token_kind,
    input logic [2:0]  i_error_code,
    input logic [15:0] i_token_length,
    input logic [7:0]  i_offending_byte,
    input logic        i_last_of_run
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result channel valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid &&
            $stable({i_token_kind, i_error_code, i_token_length, i_offending_byte,
                     i_last_of_run})))
        else $error("stalled result transaction changed");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_token_kind == K_END) |-> (i_last_of_run && i_token_length == 16'd0))
        else $error("end token not last of its run");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_token_kind == K_ERROR) |->
            (i_token_length == 16'd1 && i_error_code != E_NONE))
        else $error("malformed error token");

    a_clean_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_token_kind != K_ERROR) |->
            (i_error_code == E_NONE && i_offending_byte == 8'h00))
        else $error("error fields set on a non-error token");

endmodule

bind bracket_format_lexer bfl_checker u_bfl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_token_kind     (o_out.token_kind),
    .i_error_code     (o_out.error_code),
    .i_token_length   (o_out.token_length),
    .i_offending_byte (o_out.offending_byte),
    .i_last_of_run    (o_out.last_of_run)
);
